// File: src/rs485_frame_builder_checksum_defines.svh
// assertion macros for the frame builder
`ifndef RS485_FRAME_BUILDER_CHECKSUM_DEFINES_SVH
`define RS485_FRAME_BUILDER_CHECKSUM_DEFINES_SVH

// condition must hold at every edge out of reset
`define FBC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold after the antecedent, as a non-overlapping implication
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fbc_pkg.sv
// shared types and constants for the frame builder
`default_nettype none
package fbc_pkg;

	localparam int unsigned NUM_SLOTS  = 10;
	localparam int unsigned SLOT_W     = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_ITEM_W  = 46;

	localparam logic [5:0] MAX_WORDS   = 6'd62;
	localparam logic [7:0] LEN_BASE    = 8'd6;
	localparam logic [7:0] PING_LEN    = 8'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_ADDR  = 2'd0,
		CFG_HDR_START = 2'd1,
		CFG_TXT_START = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [5:0]  word_count;
		logic [7:0]  destination;
	} item_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] bytes;
		logic [SLOT_W-1:0]         last_idx;
		logic                      close;
		logic                      err;
	} plan_t;

endpackage
`default_nettype wire

// File: src/fbc_plan.sv
// input register, configuration registers and per-item frame byte planning
`default_nettype none
`include "rs485_frame_builder_checksum_defines.svh"
module fbc_plan import fbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_wr_t              cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_opcode,
	input  wire item_t                in_item,
	output logic                      plan_valid,
	input  wire logic                 plan_ready,
	output plan_t                     plan
);

	logic       valid_s1;
	logic       opcode_s1;
	item_t      item_s1;
	logic [7:0] own_addr_q;
	logic [7:0] hdr_start_q;
	logic [7:0] txt_start_q;
	logic [7:0] running_sum_q;
	logic [5:0] words_left_q;

	logic       take;
	logic       use_hdr;
	logic       use_word;
	logic       use_ck;
	logic       is_err;
	logic [7:0] hdr_len;
	logic [7:0] hdr_sum;
	logic [7:0] word_sum;
	logic [7:0] total;
	logic [7:0] ck_byte;
	logic [7:0] sum_d;
	logic [5:0] wl_d;
	logic [3:0][7:0] wb;

	assign take       = valid_s1 && plan_ready;
	assign in_ready   = !valid_s1 || plan_ready;
	assign plan_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= in_opcode;
			item_s1   <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= 8'd0;
			hdr_start_q <= 8'd1;
			txt_start_q <= 8'd2;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_OWN_ADDR:  own_addr_q  <= cfg.data;
				CFG_HDR_START: hdr_start_q <= cfg.data;
				CFG_TXT_START: txt_start_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign wb = item_s1.data_word;

	always_comb begin
		use_hdr  = 1'b0;
		use_word = 1'b0;
		use_ck   = 1'b0;
		is_err   = 1'b0;
		hdr_len  = {item_s1.word_count, 2'b00} + LEN_BASE;
		wl_d     = words_left_q;
		if (opcode_s1) begin
			use_hdr = 1'b1;
			use_ck  = 1'b1;
			hdr_len = PING_LEN;
			wl_d    = 6'd0;
		end else if (words_left_q == 6'd0) begin
			if (item_s1.word_count == 6'd0 || item_s1.word_count > MAX_WORDS) begin
				is_err = 1'b1;
			end else begin
				use_hdr  = 1'b1;
				use_word = 1'b1;
				wl_d     = item_s1.word_count - 6'd1;
				use_ck   = (item_s1.word_count == 6'd1);
			end
		end else begin
			use_word = 1'b1;
			wl_d     = words_left_q - 6'd1;
			use_ck   = (words_left_q == 6'd1);
		end
	end

	assign hdr_sum  = hdr_start_q + hdr_len + own_addr_q + item_s1.destination + txt_start_q;
	assign word_sum = wb[3] + wb[2] + wb[1] + wb[0];
	assign total    = (use_hdr ? hdr_sum : running_sum_q) + (use_word ? word_sum : 8'd0);
	assign ck_byte  = ~total + 8'd1;

	always_comb begin
		plan       = '0;
		plan.close = use_ck;
		plan.err   = is_err;
		sum_d      = use_ck ? 8'd0 : total;
		if (is_err) begin
			sum_d         = running_sum_q;
			plan.last_idx = 4'd0;
		end else if (use_hdr) begin
			plan.bytes[0] = hdr_start_q;
			plan.bytes[1] = hdr_len;
			plan.bytes[2] = own_addr_q;
			plan.bytes[3] = item_s1.destination;
			plan.bytes[4] = txt_start_q;
			if (use_word) begin
				plan.bytes[5] = wb[3];
				plan.bytes[6] = wb[2];
				plan.bytes[7] = wb[1];
				plan.bytes[8] = wb[0];
				plan.bytes[9] = ck_byte;
				plan.last_idx = use_ck ? 4'd9 : 4'd8;
			end else begin
				plan.bytes[5] = ck_byte;
				plan.last_idx = 4'd5;
			end
		end else begin
			plan.bytes[0] = wb[3];
			plan.bytes[1] = wb[2];
			plan.bytes[2] = wb[1];
			plan.bytes[3] = wb[0];
			plan.bytes[4] = ck_byte;
			plan.last_idx = use_ck ? 4'd4 : 4'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= 8'd0;
			words_left_q  <= 6'd0;
		end else if (take) begin
			running_sum_q <= sum_d;
			words_left_q  <= wl_d;
		end
	end

	`FBC_ASSERT_ALWAYS(a_words_left_range, words_left_q <= MAX_WORDS, "words_left above limit")
	`FBC_ASSERT_NEXT(a_err_no_open, take && is_err, words_left_q == 6'd0, "error opened a message")
	`FBC_ASSERT_NEXT(a_ping_clears, take && opcode_s1,
		words_left_q == 6'd0 && running_sum_q == 8'd0, "ping left state behind")

endmodule
`default_nettype wire

// File: src/fbc_ser.sv
// plan register and byte serialiser with output register
`default_nettype none
`include "rs485_frame_builder_checksum_defines.svh"
module fbc_ser import fbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic plan_valid,
	output logic      plan_ready,
	input  wire plan_t plan,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [7:0] out_data,
	output logic      out_last,
	output logic      out_user
);

	logic              valid_s2;
	plan_t             plan_s2;
	logic [SLOT_W-1:0] idx_q;
	logic              out_load;
	logic              at_last;

	assign out_load   = valid_s2 && (!out_valid || out_ready);
	assign at_last    = (idx_q == plan_s2.last_idx);
	assign plan_ready = !valid_s2 || (out_load && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (plan_ready) begin
				valid_s2 <= plan_valid;
				idx_q    <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_ready && plan_valid) begin
			plan_s2 <= plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data <= plan_s2.bytes[idx_q];
			out_last <= plan_s2.close && at_last;
			out_user <= plan_s2.err;
		end
	end

	`FBC_ASSERT_ALWAYS(a_idx_bound, !valid_s2 || idx_q <= plan_s2.last_idx, "byte index past plan")
	`FBC_ASSERT_ALWAYS(a_err_not_last, !(out_valid && out_user && out_last),
		"error request marked as frame end")

endmodule
`default_nettype wire

// File: src/rs485_frame_builder_checksum.sv
// path: an accepted item passes the input reg, the plan reg and the output reg before its first byte shows
// throughput: one byte per cycle while m_axis_tready is high and items keep arriving; an item yields
//   4 or 5 bytes for a later word, 9 or 10 for a first word, 6 for a ping, 1 for a count error
// the byte serialiser sets this rate; the next item is taken while bytes are still going out
// reset: arst_n clears the pipeline, the message state and loads the register defaults
`default_nettype none
module rs485_frame_builder_checksum import fbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // destination, word_count, data_word
	input  wire logic                 s_axis_tuser,  // opcode
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [7:0]                m_axis_tdata,  // out_byte
	output logic                      m_axis_tlast,  // frame_end
	output logic                      m_axis_tuser,  // count_error
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	cfg_wr_t cfg;
	item_t   in_item;
	plan_t   plan;
	logic    plan_valid;
	logic    plan_ready;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign in_item   = item_t'(s_axis_tdata[IN_ITEM_W-1:0]);

	fbc_plan u_plan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_opcode  (s_axis_tuser),
		.in_item    (in_item),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan)
	);

	fbc_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_user   (m_axis_tuser)
	);

endmodule
`default_nettype wire

// File: verif/rs485_frame_builder_checksum_tb.sv
// self-checking testbench for the frame builder with byte-sum checksum
module rs485_frame_builder_checksum_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbc_pkg::*;

	localparam bit                 OP_WORD     = 1'b0;
	localparam bit                 OP_PING     = 1'b1;
	localparam logic [5:0]         COUNT_NONE  = 6'd0;
	localparam logic [5:0]         COUNT_OVER  = MAX_WORDS + 6'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned        CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       count_error;
	} tx_byte_t;

	class frame_tracker;
		bit [7:0] own_addr;
		bit [7:0] hdr_start;
		bit [7:0] txt_start;
		bit [7:0] running_sum;
		bit [5:0] words_left;
		tx_byte_t due_bytes[$];
		int       mismatches;

		function new();
			own_addr    = 8'h00;
			hdr_start   = 8'h01;
			txt_start   = 8'h02;
			running_sum = 8'h00;
			words_left  = 6'd0;
			mismatches  = 0;
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] %s", $time, what);
		endtask

		function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] value);
			case (idx)
				CFG_OWN_ADDR:  own_addr  = value;
				CFG_HDR_START: hdr_start = value;
				CFG_TXT_START: txt_start = value;
				default: ;
			endcase
		endfunction

		function void queue_due(tx_byte_t entry);
			due_bytes = {due_bytes, entry};
		endfunction

		function void put_byte(bit [7:0] b, bit last);
			queue_due('{out_byte: b, frame_end: last, count_error: 1'b0});
			running_sum += b;
		endfunction

		function void open_frame(bit [7:0] len, bit [7:0] dst);
			running_sum = 8'h00;
			put_byte(hdr_start, 1'b0);
			put_byte(len, 1'b0);
			put_byte(own_addr, 1'b0);
			put_byte(dst, 1'b0);
			put_byte(txt_start, 1'b0);
		endfunction

		function void close_frame();
			put_byte(~running_sum + 8'd1, 1'b1);
			running_sum = 8'h00;
		endfunction

		function void take_request(bit op, bit [7:0] dst, bit [5:0] cnt, bit [31:0] word);
			bit [7:0] len;
			if (op == OP_PING) begin
				words_left = 6'd0;
				open_frame(PING_LEN, dst);
				close_frame();
				return;
			end
			if (words_left == 6'd0) begin
				if (cnt == COUNT_NONE || cnt > MAX_WORDS) begin
					queue_due('{out_byte: 8'h00, frame_end: 1'b0, count_error: 1'b1});
					return;
				end
				len = {cnt, 2'b00} + LEN_BASE;
				open_frame(len, dst);
				words_left = cnt;
			end
			for (int i = 3; i >= 0; i--)
				put_byte(word[8*i +: 8], 1'b0);
			words_left--;
			if (words_left == 6'd0)
				close_frame();
		endfunction

		task check_byte(logic [7:0] b, logic last, logic err);
			tx_byte_t want;
			if (due_bytes.size() == 0) begin
				report($sformatf("unrequested byte %h last %b err %b", b, last, err));
				return;
			end
			want = due_bytes.pop_front();
			if (b !== want.out_byte)
				report($sformatf("out_byte %h, wanted %h", b, want.out_byte));
			if (last !== want.frame_end)
				report($sformatf("frame_end %b, wanted %b", last, want.frame_end));
			if (err !== want.count_error)
				report($sformatf("count_error %b, wanted %b", err, want.count_error));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	frame_tracker tracker = new();
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          rx_hold = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;

	rs485_frame_builder_checksum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready = 1'b0;
			rx_hold--;
		end else
			m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// returns just after the rising edge that accepted the request
	task automatic send_item(bit op, bit [7:0] dst, bit [5:0] cnt, bit [31:0] word);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = {{(IN_DATA_W-IN_ITEM_W){1'b0}}, word, cnt, dst};
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.take_request(op, dst, cnt, word);
		items_sent++;
	endtask

	task automatic drain(int extra);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (tracker.due_bytes.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// only while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
		@(negedge clk);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		@(posedge clk);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	task automatic send_message(bit [5:0] len);
		send_item(OP_WORD, 8'($urandom_range(255)), len, $urandom);
		for (int i = 1; i < len; i++) begin
			// abandon the open message now and then
			if ($urandom_range(99) < 3) begin
				send_item(OP_PING, 8'($urandom_range(255)), 6'($urandom_range(63)),
					$urandom);
				return;
			end
			send_item(OP_WORD, 8'($urandom_range(255)), 6'($urandom_range(63)), $urandom);
		end
	endtask

	task automatic run_random(int target);
		int stop;
		int r;
		int pick;
		stop = items_sent + target;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 6)
				send_item(OP_PING, 8'($urandom_range(255)), 6'($urandom_range(63)),
					$urandom);
			else if (r < 10)
				send_item(OP_WORD, 8'($urandom_range(255)), r[0] ? COUNT_OVER : COUNT_NONE,
					$urandom);
			else begin
				pick = $urandom_range(99);
				if (pick < 75)
					send_message(6'($urandom_range(4, 1)));
				else if (pick < 95)
					send_message(6'($urandom_range(20, 5)));
				else if (pick < 98)
					send_message(6'($urandom_range(61, 21)));
				else
					send_message(MAX_WORDS);
			end
		end
	endtask

	task automatic load_random_config();
		write_reg(CFG_OWN_ADDR, 8'($urandom_range(255)));
		write_reg(CFG_HDR_START, 8'($urandom_range(255)));
		write_reg(CFG_TXT_START, 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults, field extremes and error cases
		send_item(OP_PING, 8'h00, 6'd0, 32'h0000_0000);
		send_item(OP_PING, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_WORD, 8'h12, COUNT_NONE, 32'hDEAD_BEEF);
		send_item(OP_WORD, 8'h34, COUNT_OVER, 32'hCAFE_F00D);
		send_item(OP_WORD, 8'hFF, 6'd1, 32'h0000_0000);
		send_item(OP_WORD, 8'h00, 6'd1, 32'hFFFF_FFFF);
		send_item(OP_WORD, 8'hA5, 6'd2, 32'h0123_4567);
		send_item(OP_WORD, 8'h5A, 6'd63, 32'h89AB_CDEF);
		send_item(OP_WORD, 8'h3C, 6'd3, 32'h1357_9BDF);
		send_item(OP_PING, 8'hC3, 6'd5, 32'h2468_ACE0);
		send_item(OP_WORD, 8'h0F, COUNT_NONE, 32'h0000_0001);
		send_item(OP_WORD, 8'hF0, 6'd2, 32'h8000_0000);
		send_item(OP_WORD, 8'h11, 6'd0, 32'h7FFF_FFFF);
		drain(5);

		write_reg(CFG_OWN_ADDR, 8'hFF);
		write_reg(CFG_HDR_START, 8'h00);
		write_reg(CFG_TXT_START, 8'hFF);
		write_reg(CFG_UNUSED, 8'h5A);
		send_item(OP_PING, 8'hA5, 6'd0, 32'h0000_0000);
		send_item(OP_WORD, 8'h81, 6'd2, 32'hFF00_FF00);
		send_item(OP_WORD, 8'h7E, 6'd1, 32'h00FF_00FF);
		send_item(OP_WORD, 8'h42, COUNT_OVER, 32'h5555_AAAA);
		drain(5);

		load_random_config();
		set_idling(25, 84);
		run_random(110);
		drain(5);

		write_reg(CFG_OWN_ADDR, 8'h00);
		write_reg(CFG_HDR_START, 8'hFF);
		write_reg(CFG_TXT_START, 8'h00);
		set_idling(84, 25);
		run_random(110);
		drain(5);

		load_random_config();
		set_idling(0, 0);
		run_random(20);
		rx_hold = 300;
		run_random(20);
		drain(5);
		send_message(MAX_WORDS);
		run_random(40);

		drain(20);
		if (tracker.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/fbc_pkg.sv
src/fbc_plan.sv
src/fbc_ser.sv
src/rs485_frame_builder_checksum.sv
verif/rs485_frame_builder_checksum_tb.sv
